@@ src/omkct_pkg.sv @@
// shared types and constants of the ordered multi-key connection table
// no dependencies; every other file of the block imports this package
package omkct_pkg;

   // table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // field widths
   localparam int MODE_W   = 3;
   localparam int HANDLE_W = 16;
   localparam int FD_W     = 16;
   localparam int STACK_W  = 8;
   localparam int STATUS_W = 2;
   localparam int CAP_W    = 5;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_CAPACITY = 1'b0;
   localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

   // request modes
   localparam logic [MODE_W-1:0] MODE_ADD        = 3'd0;
   localparam logic [MODE_W-1:0] MODE_FIND_API   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FIND_TPORT = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DEL_HANDLE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DEL_STACK  = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

   // one table entry, also used as the lookup key
   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [FD_W-1:0]     api_fd;
      logic [FD_W-1:0]     tport_fd;
      logic [STACK_W-1:0]  stack;
   } entry_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic occupied;
      logic load;
      logic shift;
   } cell_ctrl_type;

   // per-cell key compare results, already qualified by occupancy
   typedef struct packed {
      logic api_fd;
      logic tport_fd;
      logic handle;
      logic stack;
   } match_type;

   // sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

@@ src/omkct_if.sv @@
// handshake channels of the ordered multi-key connection table
// depends on omkct_pkg for field widths
interface omkct_req_if;
   import omkct_pkg::*;

   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [HANDLE_W-1:0] handle;
   logic [FD_W-1:0]     api_fd;
   logic [FD_W-1:0]     tport_fd;
   logic [STACK_W-1:0]  stack_num;

   modport source (output valid, mode, handle, api_fd, tport_fd, stack_num,
                   input ready);
   modport sink (input valid, mode, handle, api_fd, tport_fd, stack_num,
                 output ready);
endinterface

interface omkct_rsp_if;
   import omkct_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [HANDLE_W-1:0] found_handle;
   logic                released;
   logic                last;

   modport source (output valid, status, found_handle, released, last,
                   input ready);
   modport sink (input valid, status, found_handle, released, last,
                 output ready);
endinterface

@@ src/omkct_cell.sv @@
// one storage cell of the connection table chain
// depends on omkct_pkg; holds one entry, compares it with the request key
module omkct_cell (
   input  logic                     clock,
   input  omkct_pkg::cell_ctrl_type ctrl,
   input  omkct_pkg::entry_type     key,
   input  omkct_pkg::entry_type     next_entry,
   output omkct_pkg::entry_type     entry,
   output omkct_pkg::match_type     match
);
   import omkct_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // load a new entry, take the neighbor's entry on removal, else hold
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.load) begin
         entry_in = key;
      end else if (ctrl.shift) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // key compares, only for cells that hold a live entry
   always_comb begin
      match.api_fd   = ctrl.occupied && (entry_ff.api_fd == key.api_fd);
      match.tport_fd = ctrl.occupied && (entry_ff.tport_fd == key.tport_fd);
      match.handle   = ctrl.occupied && (entry_ff.handle == key.handle);
      match.stack    = ctrl.occupied && (entry_ff.stack == key.stack);
   end

   assign entry = entry_ff;

endmodule

@@ src/ordered_multi_key_connection_table.sv @@
// top level of the ordered multi-key connection table
// depends on omkct_pkg, omkct_req_if, omkct_rsp_if and omkct_cell
//
// A table of up to TABLE_DEPTH connections kept in insertion order in a row of
// cells. Each transaction on the request channel adds an entry at the tail,
// finds the oldest entry by api or transport descriptor, removes the oldest
// entry with a given handle, or removes every entry of a stack. Requests are
// taken one at a time: a request is captured in the idle state and executed
// in the exec state once the result register is free. A stack purge removes
// its matching entries one at a time, oldest first, each with its own
// result, since each removal closes the gap by moving every later cell's
// entry one place toward the head. Execution also waits while the result
// register holds a transaction that has not been taken. Unused modes give no
// result. capacity_limit at byte address 0 bounds the number of entries;
// lowering it below the current count keeps the entries and refuses adds.
module ordered_multi_key_connection_table (
   input  logic                             clock,
   input  logic                             reset,
   omkct_req_if.sink                        req_ch,
   omkct_rsp_if.source                      rsp_ch,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [omkct_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [omkct_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [omkct_pkg::CSR_DATA_W-1:0] prdata,
   output logic                             pready
);
   import omkct_pkg::*;

   // configuration register
   logic [CAP_W-1:0] capacity_ff;
   logic             csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_write && (paddr[2] == REG_CAPACITY) && (paddr[1:0] == 2'b00)) begin
         capacity_ff <= pwdata[CAP_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_CAPACITY) begin
         prdata = CSR_DATA_W'(capacity_ff);
      end
   end

   // sequencer and captured request
   state_type          state_ff, state_in;
   logic [MODE_W-1:0]  mode_ff;
   entry_type          key_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               req_take;
   logic               exec_done;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff         <= req_ch.mode;
         key_ff.handle   <= req_ch.handle;
         key_ff.api_fd   <= req_ch.api_fd;
         key_ff.tport_fd <= req_ch.tport_fd;
         key_ff.stack    <= req_ch.stack_num;
      end
   end

   // chain of cells
   cell_ctrl_type              cell_ctrl  [TABLE_DEPTH];
   entry_type                  cell_entry [TABLE_DEPTH];
   match_type                  cell_match [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]     hit_api, hit_tport, hit_handle, hit_stack;
   logic [TABLE_DEPTH-1:0]     load_vec, shift_vec;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      entry_type next_entry;

      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign next_entry = cell_entry[i];
      end else begin : g_body
         assign next_entry = cell_entry[i+1];
      end

      assign cell_ctrl[i].occupied = (32'(count_ff) > i);
      assign cell_ctrl[i].load     = load_vec[i];
      assign cell_ctrl[i].shift    = shift_vec[i];

      omkct_cell u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl[i]),
         .key        (key_ff),
         .next_entry (next_entry),
         .entry      (cell_entry[i]),
         .match      (cell_match[i])
      );

      assign hit_api[i]    = cell_match[i].api_fd;
      assign hit_tport[i]  = cell_match[i].tport_fd;
      assign hit_handle[i] = cell_match[i].handle;
      assign hit_stack[i]  = cell_match[i].stack;
   end

   // oldest match of the key that this mode uses
   logic [TABLE_DEPTH-1:0] hit;
   logic [TABLE_DEPTH-1:0] first_oh;
   logic [TABLE_DEPTH-1:0] from_first;
   logic                   any_hit;
   logic                   more_hits;
   logic [HANDLE_W-1:0]    first_handle;

   always_comb begin
      case (mode_ff)
         MODE_FIND_API:   hit = hit_api;
         MODE_FIND_TPORT: hit = hit_tport;
         MODE_DEL_HANDLE: hit = hit_handle;
         MODE_DEL_STACK:  hit = hit_stack;
         default:         hit = '0;
      endcase
   end

   assign first_oh   = hit & ~(hit - TABLE_DEPTH'(1));
   assign from_first = ~(first_oh - TABLE_DEPTH'(1));
   assign any_hit    = |hit;
   assign more_hits  = |(hit & ~first_oh);

   always_comb begin
      first_handle = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         first_handle = first_handle | (first_oh[i] ? cell_entry[i].handle : '0);
      end
   end

   // execution control and result
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic                released_ff, released_in;
   logic                last_ff, last_in;
   logic                out_free;
   logic                emit;
   logic                add_ok;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign add_ok   = (32'(count_ff) < 32'(capacity_ff)) && (32'(count_ff) < TABLE_DEPTH);

   always_comb begin
      exec_done   = 1'b0;
      emit        = 1'b0;
      load_vec    = '0;
      shift_vec   = '0;
      count_in    = count_ff;
      status_in   = STATUS_OK;
      handle_in   = '0;
      released_in = 1'b0;
      last_in     = 1'b1;
      if ((state_ff == ST_EXEC) && out_free) begin
         exec_done = 1'b1;
         emit      = 1'b1;
         case (mode_ff)
            MODE_ADD: begin
               if (add_ok) begin
                  for (int i = 0; i < TABLE_DEPTH; i++) begin
                     load_vec[i] = (32'(count_ff) == i);
                  end
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  status_in = STATUS_FULL;
               end
            end
            MODE_FIND_API, MODE_FIND_TPORT: begin
               if (any_hit) begin
                  handle_in = first_handle;
               end else begin
                  status_in = STATUS_NOT_FOUND;
               end
            end
            MODE_DEL_HANDLE: begin
               if (any_hit) begin
                  shift_vec   = from_first;
                  count_in    = count_ff - CNT_W'(1);
                  handle_in   = key_ff.handle;
                  released_in = 1'b1;
               end else begin
                  status_in = STATUS_NOT_FOUND;
               end
            end
            MODE_DEL_STACK: begin
               // one removed entry per cycle while the result register is free, oldest first
               if (any_hit) begin
                  shift_vec   = from_first;
                  count_in    = count_ff - CNT_W'(1);
                  handle_in   = first_handle;
                  released_in = 1'b1;
                  last_in     = !more_hits;
                  exec_done   = !more_hits;
               end
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         status_ff   <= status_in;
         handle_ff   <= handle_in;
         released_ff <= released_in;
         last_ff     <= last_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.found_handle = handle_ff;
   assign rsp_ch.released     = released_ff;
   assign rsp_ch.last         = last_ff;

endmodule
